// ===== rtl/pdm_pkg.sv =====
package pdm_pkg;

  // field widths fixed by the register map and the result format
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned SETPOINT_W = 13;
  localparam int unsigned SP_EXT_W   = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned CORR_W     = 8;

  // output limits
  localparam logic signed [CORR_W-1:0] CORR_LIMIT = 8'sd90;
  localparam logic [SPEED_W-1:0]       SPEED_TOP  = 8'd180;

  // register reset values
  localparam logic [SETPOINT_W-1:0] SETPOINT_RST   = 13'd3500;
  localparam logic [SPEED_W-1:0]    BASE_SPEED_RST = 8'd90;
  localparam logic [SPEED_W-1:0]    MAX_SPEED_RST  = 8'd180;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT       = 3'd0,
    REG_GAINS_FORWARD  = 3'd1,
    REG_GAINS_BACKWARD = 3'd2,
    REG_BASE_SPEED     = 3'd3,
    REG_MAX_SPEED      = 3'd4,
    REG_MOTOR_INVERT   = 3'd5,
    REG_OUTPUT_ENABLE  = 3'd6
  } cfg_idx_e;

  // one gain set, unsigned q8.8, kp in the top bits
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gain_set_t;

  // all configuration as seen by the datapath
  typedef struct packed {
    logic [SETPOINT_W-1:0] setpoint;
    gain_set_t             gains_fwd;
    gain_set_t             gains_bwd;
    logic [SPEED_W-1:0]    base_speed;
    logic [SPEED_W-1:0]    max_speed;
    logic [1:0]            motor_invert;
    logic                  output_enable;
  } cfg_t;

endpackage

// ===== rtl/pdm_cfg_regs.sv =====
module pdm_cfg_regs import pdm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register writes, one per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint      <= SETPOINT_RST;
      cfg_q.gains_fwd     <= '0;
      cfg_q.gains_bwd     <= '0;
      cfg_q.base_speed    <= BASE_SPEED_RST;
      cfg_q.max_speed     <= MAX_SPEED_RST;
      cfg_q.motor_invert  <= '0;
      cfg_q.output_enable <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_SETPOINT:       cfg_q.setpoint      <= cfg_data_i[SETPOINT_W-1:0];
        REG_GAINS_FORWARD:  cfg_q.gains_fwd     <= gain_set_t'(cfg_data_i);
        REG_GAINS_BACKWARD: cfg_q.gains_bwd     <= gain_set_t'(cfg_data_i);
        REG_BASE_SPEED:     cfg_q.base_speed    <= cfg_data_i[SPEED_W-1:0];
        REG_MAX_SPEED:      cfg_q.max_speed     <= cfg_data_i[SPEED_W-1:0];
        REG_MOTOR_INVERT:   cfg_q.motor_invert  <= cfg_data_i[1:0];
        REG_OUTPUT_ENABLE:  cfg_q.output_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pdm_front.sv =====
module pdm_front import pdm_pkg::*; #(
  parameter int unsigned INTEGRATOR_BITS = 32,
  parameter int unsigned POSITION_BITS   = 13,
  parameter int unsigned CLAMP_EXP       = 32,
  parameter int unsigned ICL_W           = 34
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [POSITION_BITS-1:0]        position_i,
  input  logic                            mode_i,
  input  cfg_t                            cfg_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [POSITION_BITS:0]   err_o,
  output logic signed [POSITION_BITS+1:0] diff_o,
  output logic signed [ICL_W-1:0]         icl_o,
  output gain_set_t                       gains_o,
  output logic                            mode_o
);

  localparam int unsigned PB    = POSITION_BITS;
  localparam int unsigned IB    = INTEGRATOR_BITS;
  localparam int unsigned ERR_W = PB + 1;
  localparam int unsigned DIF_W = PB + 2;
  localparam int unsigned EXT_W = (IB > ICL_W) ? IB : ICL_W;

  localparam logic signed [EXT_W-1:0] ICL_HI =
    {{(EXT_W-CLAMP_EXP-1){1'b0}}, 1'b1, {CLAMP_EXP{1'b0}}};
  localparam logic signed [EXT_W-1:0] ICL_LO = -ICL_HI;
  localparam logic signed [IB-1:0]    INT_MAX = {1'b0, {(IB-1){1'b1}}};
  localparam logic signed [IB-1:0]    INT_MIN = {1'b1, {(IB-1){1'b0}}};

  logic                    accept;
  logic                    valid_q;
  logic [SP_EXT_W-1:0]     sp_ext;
  logic [PB-1:0]           sp;
  logic signed [ERR_W-1:0] err_d, err_q, prev_q;
  logic signed [DIF_W-1:0] diff_d, diff_q;
  logic signed [IB:0]      int_sum;
  logic signed [IB-1:0]    integral_d, integral_q;
  logic signed [EXT_W-1:0] int_ext, icl_ext;
  logic signed [ICL_W-1:0] icl_q;
  gain_set_t               gains_q;
  logic                    mode_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // error against the setpoint, masked to the position width
  assign sp_ext = SP_EXT_W'(cfg_i.setpoint);
  assign sp     = sp_ext[PB-1:0];
  assign err_d  = $signed({1'b0, sp}) - $signed({1'b0, position_i});
  assign diff_d = DIF_W'(err_d) - DIF_W'(prev_q);

  // saturating integrator
  assign int_sum = (IB+1)'(integral_q) + (IB+1)'(err_d);
  always_comb begin
    if (int_sum[IB] != int_sum[IB-1]) begin
      integral_d = int_sum[IB] ? INT_MIN : INT_MAX;
    end else begin
      integral_d = int_sum[IB-1:0];
    end
  end

  // bound the integral so that the integral product stays narrow; past the
  // bound the correction is saturated by sign anyway
  assign int_ext = EXT_W'(integral_d);
  always_comb begin
    if (int_ext > ICL_HI) begin
      icl_ext = ICL_HI;
    end else if (int_ext < ICL_LO) begin
      icl_ext = ICL_LO;
    end else begin
      icl_ext = int_ext;
    end
  end

  // loop state, updated on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      prev_q     <= '0;
    end else if (accept) begin
      integral_q <= integral_d;
      prev_q     <= err_d;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q   <= err_d;
      diff_q  <= diff_d;
      icl_q   <= icl_ext[ICL_W-1:0];
      gains_q <= mode_i ? cfg_i.gains_bwd : cfg_i.gains_fwd;
      mode_q  <= mode_i;
    end
  end

  assign out_valid_o = valid_q;
  assign err_o       = err_q;
  assign diff_o      = diff_q;
  assign icl_o       = icl_q;
  assign gains_o     = gains_q;
  assign mode_o      = mode_q;

endmodule

// ===== rtl/pdm_mul.sv =====
module pdm_mul import pdm_pkg::*; #(
  parameter int unsigned POSITION_BITS = 13,
  parameter int unsigned ICL_W         = 34
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [POSITION_BITS:0]           err_i,
  input  logic signed [POSITION_BITS+1:0]         diff_i,
  input  logic signed [ICL_W-1:0]                 icl_i,
  input  gain_set_t                               gains_i,
  input  logic                                    mode_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [POSITION_BITS+GAIN_W+1:0]  pterm_o,
  output logic signed [POSITION_BITS+GAIN_W+2:0]  dterm_o,
  output logic signed [ICL_W+GAIN_W:0]            iterm_o,
  output logic                                    mode_o
);

  localparam int unsigned P_W = POSITION_BITS + GAIN_W + 2;
  localparam int unsigned D_W = POSITION_BITS + GAIN_W + 3;
  localparam int unsigned I_W = ICL_W + GAIN_W + 1;

  logic                  accept;
  logic                  valid_q;
  logic signed [P_W-1:0] pterm_d, pterm_q;
  logic signed [D_W-1:0] dterm_d, dterm_q;
  logic signed [I_W-1:0] iterm_d, iterm_q;
  logic                  mode_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // three independent products, gains taken as non-negative
  assign pterm_d = P_W'($signed({1'b0, gains_i.kp})) * P_W'(err_i);
  assign dterm_d = D_W'($signed({1'b0, gains_i.kd})) * D_W'(diff_i);
  assign iterm_d = I_W'($signed({1'b0, gains_i.ki})) * I_W'(icl_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pterm_q <= pterm_d;
      dterm_q <= dterm_d;
      iterm_q <= iterm_d;
      mode_q  <= mode_i;
    end
  end

  assign out_valid_o = valid_q;
  assign pterm_o     = pterm_q;
  assign dterm_o     = dterm_q;
  assign iterm_o     = iterm_q;
  assign mode_o      = mode_q;

endmodule

// ===== rtl/pdm_post.sv =====
module pdm_post import pdm_pkg::*; #(
  parameter int unsigned POSITION_BITS = 13,
  parameter int unsigned ICL_W         = 34
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [POSITION_BITS+GAIN_W+1:0] pterm_i,
  input  logic signed [POSITION_BITS+GAIN_W+2:0] dterm_i,
  input  logic signed [ICL_W+GAIN_W:0]           iterm_i,
  input  logic                                   mode_i,
  input  cfg_t                                   cfg_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [CORR_W-1:0]               correction_o,
  output logic [SPEED_W-1:0]                     left_speed_o,
  output logic [SPEED_W-1:0]                     right_speed_o,
  output logic                                   drive_write_o
);

  localparam int unsigned I_W   = ICL_W + GAIN_W + 1;
  localparam int unsigned ACC_W = I_W + 2;
  localparam int unsigned Q_W   = ACC_W - 8;
  localparam int unsigned MIX_W = SPEED_W + 2;

  localparam logic signed [Q_W-1:0] Q_HI = Q_W'(CORR_LIMIT);
  localparam logic signed [Q_W-1:0] Q_LO = -Q_HI;

  // stage handshakes
  logic sum_valid_q, corr_valid_q, out_valid_q;
  logic sum_ready, corr_ready, out_ready;
  logic sum_acc, corr_acc, out_acc;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign corr_ready = !corr_valid_q || out_ready;
  assign sum_ready  = !sum_valid_q || corr_ready;
  assign in_ready_o = sum_ready;
  assign sum_acc    = in_valid_i && sum_ready;
  assign corr_acc   = sum_valid_q && corr_ready;
  assign out_acc    = corr_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q  <= 1'b0;
      corr_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (sum_ready)  sum_valid_q  <= in_valid_i;
      if (corr_ready) corr_valid_q <= sum_valid_q;
      if (out_ready)  out_valid_q  <= corr_valid_q;
    end
  end

  // pid sum in q.8
  logic signed [ACC_W-1:0] acc_d, acc_q;
  logic                    sum_mode_q;

  assign acc_d = ACC_W'(pterm_i) + ACC_W'(dterm_i) + ACC_W'(iterm_i);

  always_ff @(posedge clk_i) begin
    if (sum_acc) begin
      acc_q      <= acc_d;
      sum_mode_q <= mode_i;
    end
  end

  // drop the fraction toward zero and clamp to the correction limit
  logic signed [Q_W-1:0]    q_floor, q_trunc;
  logic                     round_up;
  logic signed [CORR_W-1:0] corr_d, corr_q;
  logic                     corr_mode_q;

  assign q_floor  = acc_q[ACC_W-1:8];
  assign round_up = acc_q[ACC_W-1] && (acc_q[7:0] != 8'd0);
  assign q_trunc  = q_floor + (round_up ? Q_W'(1) : Q_W'(0));

  always_comb begin
    if (q_trunc > Q_HI) begin
      corr_d = CORR_LIMIT;
    end else if (q_trunc < Q_LO) begin
      corr_d = -CORR_LIMIT;
    end else begin
      corr_d = q_trunc[CORR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (corr_acc) begin
      corr_q      <= corr_d;
      corr_mode_q <= sum_mode_q;
    end
  end

  // motor limit, differential mix and mirroring
  logic signed [SPEED_W:0]   head;
  logic signed [MIX_W-1:0]   lim, corr_x, applied, base_x, left_x, right_x;
  logic [SPEED_W-1:0]        left_sat, right_sat, left_d, right_d;

  assign head   = $signed({1'b0, cfg_i.max_speed}) - $signed({1'b0, cfg_i.base_speed});
  assign lim    = head[SPEED_W] ? '0 : $signed({2'b00, head[SPEED_W-1:0]});
  assign corr_x = MIX_W'(corr_q);
  assign base_x = $signed({2'b00, cfg_i.base_speed});

  always_comb begin
    if (corr_x > lim) begin
      applied = lim;
    end else if (corr_x < -lim) begin
      applied = -lim;
    end else begin
      applied = corr_x;
    end
  end

  assign left_x  = base_x + applied;
  assign right_x = base_x - applied;

  always_comb begin
    if (left_x < 0) begin
      left_sat = '0;
    end else if (left_x > $signed({2'b00, SPEED_TOP})) begin
      left_sat = SPEED_TOP;
    end else begin
      left_sat = left_x[SPEED_W-1:0];
    end
    if (right_x < 0) begin
      right_sat = '0;
    end else if (right_x > $signed({2'b00, SPEED_TOP})) begin
      right_sat = SPEED_TOP;
    end else begin
      right_sat = right_x[SPEED_W-1:0];
    end
  end

  assign left_d  = (cfg_i.motor_invert[0] != corr_mode_q) ? SPEED_TOP - left_sat : left_sat;
  assign right_d = (cfg_i.motor_invert[1] != corr_mode_q) ? SPEED_TOP - right_sat : right_sat;

  // result register
  logic signed [CORR_W-1:0] out_corr_q;
  logic [SPEED_W-1:0]       out_left_q, out_right_q;
  logic                     out_drive_q;

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      out_corr_q  <= corr_q;
      out_left_q  <= left_d;
      out_right_q <= right_d;
      out_drive_q <= cfg_i.output_enable;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign correction_o  = out_corr_q;
  assign left_speed_o  = out_left_q;
  assign right_speed_o = out_right_q;
  assign drive_write_o = out_drive_q;

endmodule

// ===== rtl/pid_differential_drive_mixer.sv =====
// a transfer writes the front register, then the product, sum, clamp and result ones in turn;
// the result one drives the master side. throughput: one item per cycle while results are taken;
// each stage holds one item and moves on when the next frees; the integrator and previous error
// update in the first stage, so items follow back to back
// reset (rst_ni low, asynchronous): pipeline emptied, loop state zeroed,
// registers back to their defaults (setpoint 3500, base 90, max 180, all else zero)
module pid_differential_drive_mixer import pdm_pkg::*; #(
  parameter int unsigned INTEGRATOR_BITS = 32,
  parameter int unsigned POSITION_BITS   = 13
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                 cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((POSITION_BITS+7)/8)*8-1:0]    s_axis_tdata,  // position
  input  logic                                  s_axis_tuser,  // mode
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [CORR_W+2*SPEED_W-1:0]           m_axis_tdata,  // correction, left_speed, right_speed
  output logic                                  m_axis_tuser   // drive_write
);

  localparam int unsigned PB        = POSITION_BITS;
  localparam int unsigned CLAMP_EXP = PB + 19;
  localparam int unsigned ICL_W     = CLAMP_EXP + 2;

  cfg_t cfg;

  pdm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // front stage: error, integrator, gain select
  logic                        f_valid, f_ready;
  logic signed [PB:0]          f_err;
  logic signed [PB+1:0]        f_diff;
  logic signed [ICL_W-1:0]     f_icl;
  gain_set_t                   f_gains;
  logic                        f_mode;

  pdm_front #(
    .INTEGRATOR_BITS (INTEGRATOR_BITS),
    .POSITION_BITS   (POSITION_BITS),
    .CLAMP_EXP       (CLAMP_EXP),
    .ICL_W           (ICL_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .position_i  (s_axis_tdata[PB-1:0]),
    .mode_i      (s_axis_tuser),
    .cfg_i       (cfg),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .err_o       (f_err),
    .diff_o      (f_diff),
    .icl_o       (f_icl),
    .gains_o     (f_gains),
    .mode_o      (f_mode)
  );

  // product stage
  logic                             m_valid, m_ready;
  logic signed [PB+GAIN_W+1:0]      m_pterm;
  logic signed [PB+GAIN_W+2:0]      m_dterm;
  logic signed [ICL_W+GAIN_W:0]     m_iterm;
  logic                             m_mode;

  pdm_mul #(
    .POSITION_BITS (POSITION_BITS),
    .ICL_W         (ICL_W)
  ) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .err_i       (f_err),
    .diff_i      (f_diff),
    .icl_i       (f_icl),
    .gains_i     (f_gains),
    .mode_i      (f_mode),
    .out_valid_o (m_valid),
    .out_ready_i (m_ready),
    .pterm_o     (m_pterm),
    .dterm_o     (m_dterm),
    .iterm_o     (m_iterm),
    .mode_o      (m_mode)
  );

  // sum, correction clamp, mixing and result register
  logic signed [CORR_W-1:0] corr;
  logic [SPEED_W-1:0]       left_speed, right_speed;

  pdm_post #(
    .POSITION_BITS (POSITION_BITS),
    .ICL_W         (ICL_W)
  ) u_post (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (m_valid),
    .in_ready_o    (m_ready),
    .pterm_i       (m_pterm),
    .dterm_i       (m_dterm),
    .iterm_i       (m_iterm),
    .mode_i        (m_mode),
    .cfg_i         (cfg),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .correction_o  (corr),
    .left_speed_o  (left_speed),
    .right_speed_o (right_speed),
    .drive_write_o (m_axis_tuser)
  );

  assign m_axis_tdata = {right_speed, left_speed, corr};

endmodule

// ===== rtl/pdm_checker.sv =====
module pdm_checker import pdm_pkg::*; (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_ready_o,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [CORR_W+2*SPEED_W-1:0]        m_axis_tdata,
  input logic                               m_axis_tuser
);

  // nothing leaves the block while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // correction and both speeds stay inside their limits
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[7:0]) <= CORR_LIMIT) &&
      ($signed(m_axis_tdata[7:0]) >= -CORR_LIMIT) &&
      (m_axis_tdata[15:8] <= SPEED_TOP) &&
      (m_axis_tdata[23:16] <= SPEED_TOP))
    else $error("result field out of range");

  // the input side is ready whenever the result side is empty
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && $past(!m_axis_tvalid) && $past(!m_axis_tvalid, 2) &&
    $past(!m_axis_tvalid, 3) && $past(!m_axis_tvalid, 4) && $past(rst_ni, 4)
      |-> s_axis_tready)
    else $error("input stalled with an empty pipeline");

  // configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind pid_differential_drive_mixer pdm_checker u_pdm_checker (.*);

// ===== tb/sv/pid_differential_drive_mixer_test.sv =====
`timescale 1ns / 1ps

module pid_differential_drive_mixer_test;
  import pdm_pkg::*;

  localparam int unsigned PIPE_LATENCY = 5;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned PHASES       = 13;
  localparam int unsigned PHASE_ITEMS  = 86;
  localparam logic [12:0] POS_TOP      = 13'd8191;
  localparam longint      ISUM_MAX     = 64'sd2147483647;
  localparam longint      ISUM_MIN     = -64'sd2147483648;
  localparam longint      ITERM_CLAMP  = 64'sd1099511627776;
  localparam longint      CORR_MAX     = 90;
  localparam longint      SPEED_MAX    = 180;

  // one steering result as it leaves the block
  typedef struct {
    logic signed [7:0] corr;
    logic [7:0]        left_spd;
    logic [7:0]        right_spd;
    logic              drive;
  } steer_t;

  typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_MOSTLY} ready_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    idx;
    logic [47:0] data;
    logic [12:0] pos;
    logic        mode;
    int unsigned reps;
    bit          typed;
    steer_t      want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i   = REG_SETPOINT;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;  // position
  logic                  s_axis_tuser  = 1'b0; // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;        // correction, left_speed, right_speed
  logic                  m_axis_tuser;        // drive_write

  pid_differential_drive_mixer u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  // steering model state and register copies
  logic [12:0] sp_reg;
  gain_set_t   fwd_gains;
  gain_set_t   bwd_gains;
  logic [7:0]  base_reg;
  logic [7:0]  max_reg;
  logic [1:0]  invert_reg;
  logic        enable_reg;
  longint      error_sum;
  longint      last_error;

  steer_t      expected_q[$];
  stim_row_t   directed_rows[$];
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;
  bit          hold_request = 1'b0;
  bit          steady_ready = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // pid step plus differential mix, updates the loop state
  function automatic steer_t predict_steering(logic [12:0] pos, logic mode);
    gain_set_t g;
    longint    kp, ki, kd, err, iterm, acc, corr, lim, applied, lspd, rspd;
    steer_t    res;
    g  = mode ? bwd_gains : fwd_gains;
    kp = g.kp;
    ki = g.ki;
    kd = g.kd;
    err       = longint'(sp_reg) - longint'(pos);
    error_sum = clamp_to(error_sum + err, ISUM_MIN, ISUM_MAX);
    iterm = clamp_to(error_sum, -ITERM_CLAMP, ITERM_CLAMP);
    iterm = clamp_to(ki * iterm, -ITERM_CLAMP, ITERM_CLAMP);
    acc   = kp * err + iterm + kd * (err - last_error);
    corr  = clamp_to(acc / 256, -CORR_MAX, CORR_MAX);
    last_error = err;
    // motor headroom is zero when max sits below base
    lim = longint'(max_reg) - longint'(base_reg);
    if (lim < 0) lim = 0;
    applied = clamp_to(corr, -lim, lim);
    lspd = clamp_to(longint'(base_reg) + applied, 0, SPEED_MAX);
    rspd = clamp_to(longint'(base_reg) - applied, 0, SPEED_MAX);
    if (invert_reg[0] != mode) lspd = SPEED_MAX - lspd;
    if (invert_reg[1] != mode) rspd = SPEED_MAX - rspd;
    res.corr      = corr[7:0];
    res.left_spd  = lspd[7:0];
    res.right_spd = rspd[7:0];
    res.drive     = enable_reg;
    return res;
  endfunction

  function automatic void apply_register(cfg_idx_e idx, logic [47:0] data);
    case (idx)
      REG_SETPOINT:       sp_reg     = data[12:0];
      REG_GAINS_FORWARD:  fwd_gains  = data;
      REG_GAINS_BACKWARD: bwd_gains  = data;
      REG_BASE_SPEED:     base_reg   = data[7:0];
      REG_MAX_SPEED:      max_reg    = data[7:0];
      REG_MOTOR_INVERT:   invert_reg = data[1:0];
      REG_OUTPUT_ENABLE:  enable_reg = data[0];
      default: ;
    endcase
  endfunction

  function automatic gain_set_t rand_gains();
    gain_set_t g;
    g.kp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
    g.ki = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    g.kd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
    return g;
  endfunction

  // directed table builders
  function automatic stim_row_t blank_row(row_kind_e kind);
    stim_row_t r;
    r.kind  = kind;
    r.idx   = REG_SETPOINT;
    r.data  = '0;
    r.pos   = '0;
    r.mode  = 1'b0;
    r.reps  = 0;
    r.typed = 1'b0;
    r.want  = '{default: '0};
    return r;
  endfunction

  function automatic void row_write(cfg_idx_e idx, logic [47:0] data);
    stim_row_t r;
    r = blank_row(ROW_WRITE);
    r.idx  = idx;
    r.data = data;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_sample(logic [12:0] pos, logic mode, int unsigned reps);
    stim_row_t r;
    r = blank_row(ROW_SAMPLE);
    r.pos  = pos;
    r.mode = mode;
    r.reps = reps;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_typed(logic [12:0] pos, logic mode, int corr, int lspd,
                                    int rspd, logic drv);
    stim_row_t r;
    r = blank_row(ROW_SAMPLE);
    r.pos   = pos;
    r.mode  = mode;
    r.reps  = 1;
    r.typed = 1'b1;
    r.want.corr      = 8'(corr);
    r.want.left_spd  = 8'(lspd);
    r.want.right_spd = 8'(rspd);
    r.want.drive     = drv;
    directed_rows.push_back(r);
  endfunction

  task automatic note_mismatch(string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // sender bursts, valid drops only between bursts
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  // one input transfer, starts and ends on a falling edge
  task automatic offer_sample(logic [12:0] pos, logic mode, bit typed, steer_t typed_res);
    steer_t guess;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, pos};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    guess = predict_steering(pos, mode);
    expected_q.push_back(typed ? typed_res : guess);
    @(negedge clk_i);
  endtask

  // register write once the pipeline has drained
  task automatic write_register(cfg_idx_e idx, logic [47:0] data);
    s_axis_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (PIPE_LATENCY + 2) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    apply_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin : ready_pattern
    int unsigned seg_left;
    ready_kind_e seg_kind;
    seg_left = 0;
    seg_kind = RDY_ALWAYS;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (steady_ready) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_kind = ready_kind_e'($urandom_range(0, 3));
          seg_left = $urandom_range(4, 48);
        end
        seg_left--;
        case (seg_kind)
          RDY_ALWAYS: m_axis_tready <= 1'b1;
          RDY_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
          RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:    m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // result check against the oldest expectation, plus stall watchdog
  always @(posedge clk_i) begin : result_check
    steer_t got;
    steer_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.corr      = m_axis_tdata[7:0];
        got.left_spd  = m_axis_tdata[15:8];
        got.right_spd = m_axis_tdata[23:16];
        got.drive     = m_axis_tuser;
        if (expected_q.size() == 0) begin
          note_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_q.pop_front();
          check_field("correction", got.corr, want.corr);
          check_field("left_speed", got.left_spd, want.left_spd);
          check_field("right_speed", got.right_spd, want.right_spd);
          check_field("drive_write", {7'd0, got.drive}, {7'd0, want.drive});
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("pid_differential_drive_mixer_test: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    steer_t      no_res;
    int unsigned ph;
    int unsigned n;
    int          p;
    int          spread;
    logic [12:0] pos;
    logic [47:0] fill;
    logic [7:0]  base_v;
    logic [7:0]  max_v;

    rst_ni    <= 1'b0;
    no_res     = '{default: '0};
    sp_reg     = SETPOINT_RST;
    fwd_gains  = '0;
    bwd_gains  = '0;
    base_reg   = BASE_SPEED_RST;
    max_reg    = MAX_SPEED_RST;
    invert_reg = 2'b00;
    enable_reg = 1'b0;
    error_sum  = 0;
    last_error = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero gains after reset: no correction, speeds sit at base
    row_typed(13'd0, 1'b0, 0, 90, 90, 1'b0);
    row_typed(POS_TOP, 1'b1, 0, 90, 90, 1'b0);
    row_write(REG_OUTPUT_ENABLE, 48'd1);
    row_typed(13'd3500, 1'b0, 0, 90, 90, 1'b1);
    // full proportional gain drives the correction into its clamp
    row_write(REG_GAINS_FORWARD, {16'hFFFF, 16'h0000, 16'h0000});
    row_write(REG_GAINS_BACKWARD, {16'hFFFF, 16'h0000, 16'h0000});
    row_typed(13'd0, 1'b0, 90, 180, 0, 1'b1);
    row_typed(POS_TOP, 1'b0, -90, 0, 180, 1'b1);
    row_typed(POS_TOP, 1'b1, -90, 180, 0, 1'b1);
    // inverted motors mirror when the flag differs from the direction
    row_write(REG_MOTOR_INVERT, 48'd3);
    row_typed(13'd0, 1'b0, 90, 0, 180, 1'b1);
    row_typed(13'd0, 1'b1, 90, 180, 0, 1'b1);
    // max below base leaves no headroom
    row_write(REG_MAX_SPEED, 48'd50);
    row_typed(13'd0, 1'b0, 90, 90, 90, 1'b1);
    // out-of-range base and max saturate the speeds
    row_write(REG_BASE_SPEED, 48'd200);
    row_write(REG_MAX_SPEED, 48'd255);
    row_typed(13'd0, 1'b1, 90, 180, 145, 1'b1);
    row_write(REG_BASE_SPEED, 48'd0);
    row_write(REG_MAX_SPEED, 48'd180);
    row_typed(POS_TOP, 1'b1, -90, 0, 90, 1'b1);
    // speeds still reported with the drive disabled
    row_write(REG_OUTPUT_ENABLE, 48'd0);
    row_typed(POS_TOP, 1'b0, -90, 180, 90, 1'b0);
    // moderate gains near the setpoint
    row_write(REG_GAINS_FORWARD, {16'h0100, 16'h0002, 16'h0040});
    row_write(REG_BASE_SPEED, 48'd90);
    row_write(REG_MOTOR_INVERT, 48'd1);
    row_sample(13'd3480, 1'b0, 1);
    row_sample(13'd3520, 1'b0, 1);
    row_sample(13'd3500, 1'b0, 1);
    row_sample(13'd3500, 1'b1, 1);
    // large integral one way, swing through zero to the other sign, then back
    row_write(REG_GAINS_FORWARD, 48'hFFFF_FFFF_FFFF);
    row_write(REG_SETPOINT, 48'd8191);
    row_sample(13'd0, 1'b0, 40);
    row_write(REG_SETPOINT, 48'd0);
    row_sample(POS_TOP, 1'b0, 80);
    row_write(REG_SETPOINT, 48'd8191);
    row_sample(13'd0, 1'b0, 40);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_WRITE) begin
        write_register(row.idx, row.data);
      end else begin
        steady_ready = (row.reps > 1);
        for (n = 0; n < row.reps; n++) begin
          if (!steady_ready) pace_sender();
          offer_sample(row.pos, row.mode, row.typed, row.want);
        end
        steady_ready = 1'b0;
      end
    end

    // random phases, each with a fresh register setting
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 2) begin
        fill = {48{ph == 1}};
        write_register(REG_SETPOINT, fill);
        write_register(REG_GAINS_FORWARD, fill);
        write_register(REG_GAINS_BACKWARD, fill);
        write_register(REG_BASE_SPEED, fill);
        write_register(REG_MAX_SPEED, fill);
        write_register(REG_MOTOR_INVERT, fill);
        write_register(REG_OUTPUT_ENABLE, fill);
      end else begin
        base_v = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(181, 255))
                                             : 8'($urandom_range(0, 180));
        if (base_v <= 8'd180 && $urandom_range(0, 3) != 0)
          max_v = base_v + 8'($urandom_range(0, 180 - base_v));
        else
          max_v = 8'($urandom_range(0, 255));
        fill = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom})
                                           : 48'($urandom_range(0, 8191));
        write_register(REG_SETPOINT, fill);
        write_register(REG_GAINS_FORWARD, rand_gains());
        write_register(REG_GAINS_BACKWARD, rand_gains());
        write_register(REG_BASE_SPEED, {40'd0, base_v});
        write_register(REG_MAX_SPEED, {40'd0, max_v});
        write_register(REG_MOTOR_INVERT, 48'($urandom_range(0, 3)));
        write_register(REG_OUTPUT_ENABLE, 48'($urandom_range(0, 1)));
      end
      // one long receiver hold-off so the pipeline backs up
      if (ph == 4) hold_request = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pace_sender();
        if ($urandom_range(0, 19) == 0) begin
          pos = 13'($urandom);
        end else begin
          spread = ($urandom_range(0, 1) == 1) ? 60 : 400;
          p = int'(sp_reg) + $urandom_range(0, 2 * spread) - spread;
          if (p < 0) p = 0;
          if (p > 8191) p = 8191;
          pos = 13'(p);
        end
        offer_sample(pos, 1'($urandom_range(0, 1)), 1'b0, no_res);
      end
    end

    // drain and give stray results a chance to show
    s_axis_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (4 * PIPE_LATENCY) @(negedge clk_i);
    if (fail_count == 0)
      $display("pid_differential_drive_mixer_test: done, clean");
    else
      $display("pid_differential_drive_mixer_test: done, errors");
    $finish;
  end

endmodule
